// ===== src/request_duplicate_detector_assert.svh =====
// Assertion macros shared by the duplicate detector RTL.
`ifndef REQUEST_DUPLICATE_DETECTOR_ASSERT_SVH
`define REQUEST_DUPLICATE_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RDD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("request duplicate detector: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RDD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("request duplicate detector: next-cycle check failed");

`endif

// ===== src/rdd_pkg.sv =====
// Types and constants of the request duplicate detector.
`default_nettype none
package rdd_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int KEY_W = 28;
	localparam int STAMP_W = 64;
	localparam int WIN_W = 32;
	localparam int ENTRY_W = KEY_W + STAMP_W;
	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5000);

	typedef struct packed {
		logic [7:0]         requester_address;
		logic [5:0]         net_function;
		logic [7:0]         command_code;
		logic [5:0]         request_sequence;
		logic [STAMP_W-1:0] current_tick;
	} req_t;

	typedef struct packed {
		logic is_duplicate;
		logic evicted_oldest;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// Outcome of comparing one stored entry against the current item.
	typedef struct packed {
		logic expired;
		logic key_match;
		logic older;
	} cmp_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_WRITE  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage
`default_nettype wire

// ===== src/rdd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/rdd_entry_cmp.sv =====
// Shared compare unit: checks one stored entry for expiry, key match and age.
`default_nettype none
module rdd_entry_cmp (
	input  wire rdd_pkg::entry_t               entry,
	input  wire logic [rdd_pkg::KEY_W-1:0]     key,
	input  wire logic [rdd_pkg::STAMP_W-1:0]   limit,
	input  wire logic                          expire_en,
	input  wire logic [rdd_pkg::STAMP_W-1:0]   min_stamp,
	output rdd_pkg::cmp_t                      result
);
	import rdd_pkg::*;

	always_comb begin
		result.expired   = expire_en && (entry.stamp < limit);
		result.key_match = (entry.key == key);
		result.older     = (entry.stamp < min_stamp);
	end

endmodule
`default_nettype wire

// ===== src/request_duplicate_detector.sv =====
// Request duplicate detector: a sixteen-entry table of recent request keys
// with age-based expiry. Each item is handled in one pass over the table: the
// entry memory is read one entry per cycle and a single compare unit decides
// expiry, key match and age for that entry, after which the key is written
// back with the item's tick, and the result is offered after that write. One
// item is handled at a time: a new item is accepted only once the block is
// idle again after offering the last result. A result left waiting at the
// output does not stop the next item from being accepted. The table is empty
// after reset, and the expiry window register resets to 5000.
`default_nettype none
module request_duplicate_detector (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire rdd_pkg::req_t               req_data,
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output rdd_pkg::rsp_t                    rsp_data,
	input  wire logic                        cfg_we,
	input  wire logic [rdd_pkg::WIN_W-1:0]   cfg_wdata
);
	import rdd_pkg::*;

	state_t state_q;

	logic [WIN_W-1:0]       window_q;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [KEY_W-1:0]   key_q;
	logic [STAMP_W-1:0] now_q;
	logic [STAMP_W-1:0] limit_q;
	logic               expire_en_q;

	logic [CNT_W-1:0] rd_cnt_q;
	logic             proc_vld_s1;
	logic [IDX_W-1:0] proc_idx_s1;

	logic               hit_found_q;
	logic [IDX_W-1:0]   hit_slot_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_slot_q;
	logic [IDX_W-1:0]   old_slot_q;
	logic [STAMP_W-1:0] min_stamp_q;
	logic [IDX_W-1:0]   wr_slot_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic             accept;
	logic [STAMP_W:0] diff;
	logic             rd_en;
	logic             live;
	logic             last_proc;
	logic [IDX_W-1:0] wr_slot;
	logic             ram_we;
	entry_t           wr_entry;
	entry_t           rd_entry;
	logic [ENTRY_W-1:0] rd_raw;
	cmp_t             cmp;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Borrow out of now - window tells whether the tick is below the window.
	assign diff = {1'b0, req_data.current_tick} - {{(STAMP_W + 1 - WIN_W){1'b0}}, window_q};

	assign rd_en     = (state_q == ST_SCAN) && (rd_cnt_q < CNT_W'(TABLE_DEPTH));
	assign rd_entry  = entry_t'(rd_raw);
	assign live      = valid_q[proc_idx_s1] && !cmp.expired;
	assign last_proc = proc_vld_s1 && (proc_idx_s1 == IDX_W'(TABLE_DEPTH - 1));

	always_comb begin
		if (hit_found_q) begin
			wr_slot = hit_slot_q;
		end else if (free_found_q) begin
			wr_slot = free_slot_q;
		end else begin
			wr_slot = old_slot_q;
		end
	end

	assign ram_we         = (state_q == ST_WRITE);
	assign wr_entry.key   = key_q;
	assign wr_entry.stamp = now_q;

	rdd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_slot),
		.wdata (ENTRY_W'(wr_entry)),
		.re    (rd_en),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (rd_raw)
	);

	rdd_entry_cmp u_cmp (
		.entry     (rd_entry),
		.key       (key_q),
		.limit     (limit_q),
		.expire_en (expire_en_q),
		.min_stamp (min_stamp_q),
		.result    (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// Item registers and the per-item scan results need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q       <= {req_data.requester_address, req_data.net_function,
			                req_data.command_code, req_data.request_sequence};
			now_q       <= req_data.current_tick;
			limit_q     <= diff[STAMP_W-1:0];
			expire_en_q <= !diff[STAMP_W] && (diff[STAMP_W-1:0] != '0);
		end
		if (proc_vld_s1) begin
			if (live && cmp.key_match && !hit_found_q) begin
				hit_slot_q <= proc_idx_s1;
			end
			if (!live && !free_found_q) begin
				free_slot_q <= proc_idx_s1;
			end
			if ((proc_idx_s1 == '0) || cmp.older) begin
				min_stamp_q <= rd_entry.stamp;
				old_slot_q  <= proc_idx_s1;
			end
		end
		if (rd_en) begin
			proc_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
		if (state_q == ST_WRITE) begin
			wr_slot_q <= wr_slot;
		end
		// The result payload only changes when the output register is free.
		if ((state_q == ST_FINISH) && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.is_duplicate   <= hit_found_q;
			rsp_q.evicted_oldest <= !hit_found_q && !free_found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			rd_cnt_q     <= '0;
			proc_vld_s1  <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			proc_vld_s1 <= rd_en;
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_cnt_q     <= '0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (proc_vld_s1) begin
						if (valid_q[proc_idx_s1] && cmp.expired) begin
							valid_q[proc_idx_s1] <= 1'b0;
						end
						if (live && cmp.key_match) begin
							hit_found_q <= 1'b1;
						end
						if (!live) begin
							free_found_q <= 1'b1;
						end
					end
					if (last_proc) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					valid_q[wr_slot] <= 1'b1;
					state_q          <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`include "request_duplicate_detector_assert.svh"

	// A hit refreshes in place, so it can never also report an eviction.
	`RDD_ASSERT_NOW(a_dup_no_evict, rsp_valid_q, !(rsp_q.is_duplicate && rsp_q.evicted_oldest))
	// Replacing the oldest entry is only chosen when every slot is live.
	`RDD_ASSERT_NOW(a_evict_only_full, (state_q == ST_WRITE) && !hit_found_q && !free_found_q,
		&valid_q)
	// The slot written by an item is valid right after the write.
	`RDD_ASSERT_NEXT(a_slot_valid, state_q == ST_WRITE, valid_q[wr_slot_q])
	// The scan never reads past the end of the table.
	`RDD_ASSERT_NOW(a_scan_bound, state_q == ST_SCAN, rd_cnt_q <= CNT_W'(TABLE_DEPTH))

endmodule
`default_nettype wire
